[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the turbine step block.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define STP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/stp_pkg.sv]
// Package for the turbine step block: widths, fixed-point constants, microcode types
// and the microcode program. No dependencies.
`timescale 1ns / 1ps

package stp_pkg;

	// Fixed-point formats
	localparam int SPEED_FRAC_BITS = 16;
	localparam int ROTOR_W = SPEED_FRAC_BITS + 12;
	localparam int SPD_SHIFT = SPEED_FRAC_BITS - 8;
	localparam int SPD_W = 20;
	localparam int SUM_W = ROTOR_W + 3;
	localparam int DELTA_W = ROTOR_W + 2;

	// Field and register widths
	localparam int PRES_W = 16;
	localparam int GAIN_W = 12;
	localparam int DT_W = 12;
	localparam int INFLOW_W = 15;
	localparam int VIB_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Shared multiplier and datapath registers
	localparam int MUL_A_W = (ROTOR_W > 28) ? ROTOR_W : 28;
	localparam int MUL_B_W = 24;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int X_W = 28;
	localparam int QEST_W = 13;
	localparam int BASE_W = 13;
	localparam int TERM_W = 16;
	localparam int NUM_W = 20;
	localparam int PC_W = 4;

	// Product bit positions
	localparam int LAG_SHIFT = 22;
	localparam int BASE_PRE_SHIFT = 16;
	localparam int BASE_RCP_SHIFT = 32;
	localparam int TERM_RCP_SHIFT = 25;

	// Register reset values
	localparam logic [PRES_W-1:0] ATM_RESET = 16'd235;
	localparam logic [GAIN_W-1:0] SPIN_RESET = 12'd328;
	localparam logic [GAIN_W-1:0] FRIC_RESET = 12'd82;

	// Plant constants
	localparam logic [19:0] INFLOW_MAX = 20'd25600;
	localparam logic [ROTOR_W-1:0] SPEED_MAX = ROTOR_W'(4000) << SPEED_FRAC_BITS;
	localparam logic [SPD_W-1:0] SPD_LOW = 20'd2560;
	localparam logic [SPD_W-1:0] RES_LO = 20'd435200;
	localparam logic [SPD_W-1:0] RES_HI = 20'd486400;
	localparam logic [SPD_W-1:0] RES_MID = 20'd460800;
	localparam logic [SPD_W-1:0] RES_HALF = 20'd25600;
	localparam logic [SPD_W-1:0] OVR_START = 20'd921600;
	localparam logic [SPD_W-1:0] SPD_TOP = 20'd1024000;

	// Division by constants: floor(2^32/50625) with one correction step,
	// and ceil(2^25/25), exact for numerators below 2^20
	localparam logic [MUL_B_W-1:0] BASE_DIV = 24'd50625;
	localparam logic [MUL_B_W-1:0] RCP_BASE = 24'd84838;
	localparam logic [MUL_B_W-1:0] RCP_TERM = 24'd1342178;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATM = 2'd0,
		CFG_SPIN = 2'd1,
		CFG_FRIC = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [PRES_W-1:0] atm;
		logic [GAIN_W-1:0] spin;
		logic [GAIN_W-1:0] fric;
	} cfg_t;

	typedef enum logic [2:0] {
		A_ZERO, A_GAIN, A_DIFF, A_SPD, A_X, A_QEST, A_NUM
	} a_sel_t;

	typedef enum logic [2:0] {
		B_ZERO, B_DT, B_GD, B_SPD14, B_RCP_BASE, B_BASE_DIV, B_RCP_TERM
	} b_sel_t;

	typedef enum logic [3:0] {
		LD_NONE, LD_GD, LD_DELTA, LD_ROTOR, LD_X, LD_QEST, LD_PROD, LD_BASE, LD_TERM
	} ld_t;

	typedef enum logic [1:0] {
		J_NEXT, J_LOW_SPEED, J_NO_TERM
	} jmp_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		ld_t ld;
		jmp_t jmp;
		logic [PC_W-1:0] tgt;
		logic fin;
	} uop_t;

	typedef struct packed {
		logic low_speed;
		logic no_term;
	} flags_t;

	typedef struct packed {
		logic [SPD_W-1:0] speed;
		logic [INFLOW_W-1:0] inflow;
		logic [VIB_W-1:0] vib;
	} result_t;

	localparam logic [PC_W-1:0] PC_FIN = 4'd8;

	function automatic uop_t mk_uop(input a_sel_t a, input b_sel_t b, input ld_t ld,
			input jmp_t jmp, input logic fin);
		uop_t u;
		u.a_sel = a;
		u.b_sel = b;
		u.ld = ld;
		u.jmp = jmp;
		u.tgt = PC_FIN;
		u.fin = fin;
		return u;
	endfunction

	// Microcode program: one control word per step
	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			4'd0: u = mk_uop(A_GAIN, B_DT, LD_GD, J_NEXT, 1'b0);
			4'd1: u = mk_uop(A_DIFF, B_GD, LD_DELTA, J_NEXT, 1'b0);
			4'd2: u = mk_uop(A_ZERO, B_ZERO, LD_ROTOR, J_NEXT, 1'b0);
			4'd3: u = mk_uop(A_SPD, B_SPD14, LD_X, J_LOW_SPEED, 1'b0);
			4'd4: u = mk_uop(A_X, B_RCP_BASE, LD_QEST, J_NEXT, 1'b0);
			4'd5: u = mk_uop(A_QEST, B_BASE_DIV, LD_PROD, J_NEXT, 1'b0);
			4'd6: u = mk_uop(A_ZERO, B_ZERO, LD_BASE, J_NO_TERM, 1'b0);
			4'd7: u = mk_uop(A_NUM, B_RCP_TERM, LD_TERM, J_NEXT, 1'b0);
			default: u = mk_uop(A_ZERO, B_ZERO, LD_NONE, J_NEXT, 1'b1);
		endcase
		return u;
	endfunction

endpackage

[hw/rtl/stp_useq.sv]
// Microcode sequencer of the turbine step block: step counter, control ROM, jumps.
// Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_useq (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic hold,
	input  stp_pkg::flags_t flags,
	output stp_pkg::uop_t ctl,
	output logic busy,
	output logic done
);

	logic [stp_pkg::PC_W-1:0] pc_q;
	logic busy_q;
	stp_pkg::uop_t word;
	logic take;

	// Fetch the control word and mask its load when idle
	always_comb begin
		word = stp_pkg::ucode(pc_q);
		ctl = word;
		if (!busy_q) begin
			ctl.ld = stp_pkg::LD_NONE;
		end
	end

	// Resolve the conditional jump
	always_comb begin
		case (word.jmp)
			stp_pkg::J_NEXT: take = 1'b0;
			stp_pkg::J_LOW_SPEED: take = flags.low_speed;
			stp_pkg::J_NO_TERM: take = flags.no_term;
			default: take = 1'b0;
		endcase
	end

	assign busy = busy_q;
	assign done = busy_q && word.fin && !hold;

	// Advance the step counter; hold on the last step until the result can go
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (word.fin) begin
				if (!hold) begin
					busy_q <= 1'b0;
				end
			end else if (take) begin
				pc_q <= word.tgt;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

[hw/rtl/stp_dpath.sv]
// Datapath of the turbine step block: shared multiplier, rotor speed state and
// the work registers the microcode loads. Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_dpath (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [stp_pkg::PRES_W-1:0] drum_pressure,
	input  logic valve_open,
	input  logic [stp_pkg::DT_W-1:0] time_step,
	input  stp_pkg::cfg_t cfg,
	input  stp_pkg::uop_t ctl,
	output stp_pkg::flags_t flags,
	output stp_pkg::result_t res
);

	logic [stp_pkg::INFLOW_W-1:0] inflow_q;
	logic [stp_pkg::DT_W-1:0] dt_q;
	logic [stp_pkg::MUL_B_W-1:0] gd_q;
	logic [stp_pkg::DELTA_W-1:0] d_q;
	logic [stp_pkg::ROTOR_W-1:0] rotor_q;
	logic [stp_pkg::X_W-1:0] x_q;
	logic [stp_pkg::QEST_W-1:0] q_q;
	logic [stp_pkg::X_W-1:0] u_q;
	logic [stp_pkg::BASE_W-1:0] base_q;
	logic [stp_pkg::TERM_W-1:0] term_q;

	logic [16:0] over;
	logic [19:0] scaled;
	logic [stp_pkg::INFLOW_W-1:0] inflow_in;
	logic [19:0] mul36;
	logic [stp_pkg::ROTOR_W-1:0] target;
	logic spin;
	logic up;
	logic [stp_pkg::ROTOR_W-1:0] diff;
	logic [stp_pkg::GAIN_W-1:0] gain;
	logic [stp_pkg::SPD_W-1:0] s;
	logic [23:0] s14;
	logic [stp_pkg::SPD_W-1:0] ad;
	logic in_res;
	logic in_ovr;
	logic [stp_pkg::NUM_W-1:0] num;
	logic [stp_pkg::MUL_A_W-1:0] mul_a;
	logic [stp_pkg::MUL_B_W-1:0] mul_b;
	logic [stp_pkg::PROD_W-1:0] prod;
	logic [stp_pkg::SUM_W-1:0] sum;
	logic [stp_pkg::ROTOR_W-1:0] rotor_n;
	logic [stp_pkg::X_W-1:0] rem;
	logic [16:0] vsum;

	// Steam inflow: pressure above ambient, 16 per psi step, capped at 100 percent
	always_comb begin
		over = {1'b0, drum_pressure} - {1'b0, cfg.atm};
		scaled = {over[15:0], 4'b0000};
		inflow_in = '0;
		if (valve_open && !over[16] && (over != 17'd0)) begin
			inflow_in = (scaled > stp_pkg::INFLOW_MAX) ? stp_pkg::INFLOW_MAX[14:0]
				: scaled[14:0];
		end
	end

	// Lag operands: target speed, signed distance and gain
	always_comb begin
		mul36 = ({5'b0, inflow_q} << 5) + ({5'b0, inflow_q} << 2);
		target = stp_pkg::ROTOR_W'(mul36) << stp_pkg::SPD_SHIFT;
		spin = (inflow_q != '0);
		up = (target >= rotor_q);
		if (!spin) begin
			diff = rotor_q;
		end else if (up) begin
			diff = target - rotor_q;
		end else begin
			diff = rotor_q - target;
		end
		gain = spin ? cfg.spin : cfg.fric;
	end

	// Speed in 1/256 rpm and the vibration range tests
	always_comb begin
		s = rotor_q[stp_pkg::SPD_SHIFT +: stp_pkg::SPD_W];
		s14 = ({4'b0, s} << 4) - ({4'b0, s} << 1);
		ad = (s >= stp_pkg::RES_MID) ? (s - stp_pkg::RES_MID) : (stp_pkg::RES_MID - s);
		in_res = (s > stp_pkg::RES_LO) && (s < stp_pkg::RES_HI);
		in_ovr = (s > stp_pkg::OVR_START);
		num = in_res ? ((stp_pkg::RES_HALF - ad) << 1) : ((s - stp_pkg::OVR_START) << 3);
		flags.low_speed = (s <= stp_pkg::SPD_LOW);
		flags.no_term = !(in_res || in_ovr);
	end

	// Shared multiplier operand select
	always_comb begin
		case (ctl.a_sel)
			stp_pkg::A_GAIN: mul_a = stp_pkg::MUL_A_W'(gain);
			stp_pkg::A_DIFF: mul_a = stp_pkg::MUL_A_W'(diff);
			stp_pkg::A_SPD: mul_a = stp_pkg::MUL_A_W'(s);
			stp_pkg::A_X: mul_a = stp_pkg::MUL_A_W'(x_q);
			stp_pkg::A_QEST: mul_a = stp_pkg::MUL_A_W'(q_q);
			stp_pkg::A_NUM: mul_a = stp_pkg::MUL_A_W'(num);
			default: mul_a = '0;
		endcase
		case (ctl.b_sel)
			stp_pkg::B_DT: mul_b = stp_pkg::MUL_B_W'(dt_q);
			stp_pkg::B_GD: mul_b = gd_q;
			stp_pkg::B_SPD14: mul_b = s14;
			stp_pkg::B_RCP_BASE: mul_b = stp_pkg::RCP_BASE;
			stp_pkg::B_BASE_DIV: mul_b = stp_pkg::BASE_DIV;
			stp_pkg::B_RCP_TERM: mul_b = stp_pkg::RCP_TERM;
			default: mul_b = '0;
		endcase
	end

	assign prod = mul_a * mul_b;

	// Rotor update: move by the lag step, floor at zero, clamp at full speed
	always_comb begin
		sum = stp_pkg::SUM_W'(rotor_q) + stp_pkg::SUM_W'(d_q);
		if (spin && up) begin
			rotor_n = (sum > stp_pkg::SUM_W'(stp_pkg::SPEED_MAX)) ? stp_pkg::SPEED_MAX
				: sum[stp_pkg::ROTOR_W-1:0];
		end else if (stp_pkg::DELTA_W'(rotor_q) <= d_q) begin
			rotor_n = '0;
		end else begin
			rotor_n = rotor_q - d_q[stp_pkg::ROTOR_W-1:0];
		end
	end

	assign rem = x_q - u_q;

	// Hold the rotor speed across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_q <= '0;
		end else if (ctl.ld == stp_pkg::LD_ROTOR) begin
			rotor_q <= rotor_n;
		end
	end

	// Capture the item and load work registers as the microcode says
	always_ff @(posedge clk) begin
		if (start) begin
			inflow_q <= inflow_in;
			dt_q <= time_step;
		end
		case (ctl.ld)
			stp_pkg::LD_GD: gd_q <= prod[stp_pkg::MUL_B_W-1:0];
			stp_pkg::LD_DELTA: d_q <= prod[stp_pkg::LAG_SHIFT +: stp_pkg::DELTA_W];
			stp_pkg::LD_X: x_q <= prod[stp_pkg::BASE_PRE_SHIFT +: stp_pkg::X_W];
			stp_pkg::LD_QEST: q_q <= prod[stp_pkg::BASE_RCP_SHIFT +: stp_pkg::QEST_W];
			stp_pkg::LD_PROD: u_q <= prod[stp_pkg::X_W-1:0];
			stp_pkg::LD_BASE: base_q <= q_q
				+ stp_pkg::BASE_W'(rem >= stp_pkg::X_W'(stp_pkg::BASE_DIV));
			stp_pkg::LD_TERM: term_q <= prod[stp_pkg::TERM_RCP_SHIFT +: stp_pkg::TERM_W];
			default: ;
		endcase
	end

	// Result: sum the vibration terms, saturate, silence at low speed
	always_comb begin
		vsum = 17'(base_q) + (flags.no_term ? 17'd0 : 17'(term_q));
		res.speed = s;
		res.inflow = inflow_q;
		if (flags.low_speed) begin
			res.vib = '0;
		end else if (vsum[16]) begin
			res.vib = '1;
		end else begin
			res.vib = vsum[stp_pkg::VIB_W-1:0];
		end
	end

endmodule

[hw/rtl/steam_turbine_plant_step_unit.sv]
// Top level of the turbine step block: configuration registers, handshakes and
// the output register. Depends on stp_pkg, stp_useq and stp_dpath.
`timescale 1ns / 1ps

// One input item is one simulation tick (boiler pressure, valve state, time step);
// each item gives exactly one result item (rotor speed, steam inflow, vibration).
// Both channels use valid/ready. The configuration port writes atmospheric
// pressure (index 0), spin-up gain (1) and friction gain (2) when cfg_wen is
// high; write only while no item is in flight.
// An accepted item runs a microcode program of 5 to 9 steps on one shared
// multiplier; the step count depends on two jumps (low speed ends early, no
// resonance or overspeed term skips the last multiply). The result is loaded
// into the output register as the last step ends, and in_ready returns in the
// cycle after the last step, so a new item is taken only once the last is through.
// The finished result sits in an output register: the next item is accepted and
// processed while it waits. If it is still not taken when the next item
// finishes, the sequencer holds on its last step and in_ready stays low.
// Reset clears the rotor speed to zero, loads the register defaults and empties
// the output register.
module steam_turbine_plant_step_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic [stp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [stp_pkg::PRES_W-1:0] drum_pressure,
	input  logic valve_open,
	input  logic [stp_pkg::DT_W-1:0] time_step,
	output logic out_valid,
	input  logic out_ready,
	output logic [stp_pkg::SPD_W-1:0] turbine_speed,
	output logic [stp_pkg::INFLOW_W-1:0] inflow_percent,
	output logic [stp_pkg::VIB_W-1:0] vibration
);

	stp_pkg::cfg_t cfg_q;
	stp_pkg::uop_t ctl;
	stp_pkg::flags_t flags;
	stp_pkg::result_t res;
	stp_pkg::result_t out_q;
	logic out_valid_q;
	logic busy;
	logic done;
	logic start;
	logic hold;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.atm <= stp_pkg::ATM_RESET;
			cfg_q.spin <= stp_pkg::SPIN_RESET;
			cfg_q.fric <= stp_pkg::FRIC_RESET;
		end else if (cfg_wen) begin
			case (stp_pkg::cfg_idx_t'(cfg_index))
				stp_pkg::CFG_ATM: cfg_q.atm <= cfg_data[stp_pkg::PRES_W-1:0];
				stp_pkg::CFG_SPIN: cfg_q.spin <= cfg_data[stp_pkg::GAIN_W-1:0];
				stp_pkg::CFG_FRIC: cfg_q.fric <= cfg_data[stp_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !busy;
	assign start = in_valid && !busy;
	assign hold = out_valid_q && !out_ready;

	stp_useq u_useq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.hold(hold),
		.flags(flags),
		.ctl(ctl),
		.busy(busy),
		.done(done)
	);

	stp_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.drum_pressure(drum_pressure),
		.valve_open(valve_open),
		.time_step(time_step),
		.cfg(cfg_q),
		.ctl(ctl),
		.flags(flags),
		.res(res)
	);

	// Output register: load on the last step, drop when the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign turbine_speed = out_q.speed;
	assign inflow_percent = out_q.inflow;
	assign vibration = out_q.vib;

endmodule

[hw/rtl/stp_checker.sv]
// Port-level checker for the turbine step block, bound to the top level.
// Depends on stp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [stp_pkg::SPD_W-1:0] turbine_speed,
	input logic [stp_pkg::INFLOW_W-1:0] inflow_percent,
	input logic [stp_pkg::VIB_W-1:0] vibration
);

	logic out_stall;
	logic inflow_ok;
	logic speed_ok;
	logic slow_out;

	// Port conditions the properties test
	assign out_stall = out_valid && !out_ready;
	assign inflow_ok = (inflow_percent <= stp_pkg::INFLOW_MAX[14:0]);
	assign speed_ok = (turbine_speed <= stp_pkg::SPD_TOP);
	assign slow_out = out_valid && (turbine_speed <= stp_pkg::SPD_LOW);

	// One item at a time: taking an item closes the input in the next cycle
	`STP_ASSERT_NEXT(a_single_item, in_valid && in_ready, !in_ready, "item accepted while busy")

	// A waiting result stays valid and its vibration holds until taken
	`STP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(vibration), "result moved in stall")

	// Inflow never exceeds 100 percent
	`STP_ASSERT(a_inflow_cap, out_valid |-> inflow_ok, "inflow above full scale")

	// Speed never exceeds 4000 rpm
	`STP_ASSERT(a_speed_cap, out_valid |-> speed_ok, "speed above clamp")

	// No vibration at or below 10 rpm
	`STP_ASSERT(a_quiet_low, slow_out |-> vibration == '0, "vibration at standstill")

endmodule

bind steam_turbine_plant_step_unit stp_checker u_stp_checker (.*);

[tb/steam_turbine_plant_step_unit_tb.sv]
// Self-checking testbench for the turbine step block: one tick per item, with a
// fixed-point plant predictor in a scoreboard class. Depends on stp_pkg and the RTL.
`timescale 1ns / 1ps

module steam_turbine_plant_step_unit_tb;

	// Register index with no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [15:0] ATM_DEFAULT = 16'd235;

	// Plant constants, rotor kept with 16 fraction bits and speed with 8
	localparam logic [63:0] FULL_INFLOW = 64'd25600;
	localparam logic [63:0] ROTOR_TOP = 64'd4000 << 16;
	localparam logic [63:0] QUIET_SPEED = 64'd2560;
	localparam logic [63:0] RES_LOW = 64'd435200;
	localparam logic [63:0] RES_HIGH = 64'd486400;
	localparam logic [63:0] RES_CENTER = 64'd460800;
	localparam logic [63:0] RES_WIDTH = 64'd25600;
	localparam logic [63:0] OVERSPEED = 64'd921600;
	localparam logic [63:0] VIB_TOP = 64'd65535;

	localparam int ITEMS_PER_PHASE = 250;
	localparam int PHASES = 7;
	localparam int DRAIN_CYCLES = 30;
	localparam int CYCLE_LIMIT = 600000;

	typedef enum int {RX_FLOW, RX_HOLD, RX_CHOPPY} rx_mode_t;
	typedef enum int {TICK_SPIN, TICK_COAST, TICK_NOISE} tick_kind_t;

	// Plant predictor and queue of results still owed by the block
	class turbine_scoreboard;
		logic [15:0] atm;
		logic [11:0] spin_gain;
		logic [11:0] fric_gain;
		logic [63:0] rotor;
		stp_pkg::result_t pending_results[$];
		int mismatch_count;

		function new();
			atm = ATM_DEFAULT;
			spin_gain = 12'd328;
			fric_gain = 12'd82;
			rotor = '0;
			mismatch_count = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				stp_pkg::CFG_ATM: atm = data;
				stp_pkg::CFG_SPIN: spin_gain = data[11:0];
				stp_pkg::CFG_FRIC: fric_gain = data[11:0];
				default: ;
			endcase
		endfunction

		task report(string msg);
			mismatch_count++;
			$display("ERROR @%0t: %s", $realtime, msg);
		endtask

		// Advance the rotor by one tick and queue the result it gives
		function void note_tick(logic [15:0] boiler, logic valve, logic [11:0] dt);
			logic [63:0] b, a, step, sg, fg, inflow, target, delta, s, vib, off_mid;
			stp_pkg::result_t res;
			b = 64'(boiler);
			a = 64'(atm);
			step = 64'(dt);
			sg = 64'(spin_gain);
			fg = 64'(fric_gain);
			inflow = 64'd0;
			if (valve && b > a) begin
				inflow = (b - a) * 64'd16;
				if (inflow > FULL_INFLOW)
					inflow = FULL_INFLOW;
			end
			if (inflow != 64'd0) begin
				target = (inflow * 64'd36) << 8;
				if (target >= rotor) begin
					delta = ((target - rotor) * sg * step) >> 22;
					rotor = rotor + delta;
				end else begin
					delta = ((rotor - target) * sg * step) >> 22;
					rotor = (delta >= rotor) ? 64'd0 : rotor - delta;
				end
			end else begin
				delta = (rotor * fg * step) >> 22;
				rotor = (delta >= rotor) ? 64'd0 : rotor - delta;
			end
			if (rotor > ROTOR_TOP)
				rotor = ROTOR_TOP;

			s = rotor >> 8;
			vib = 64'd0;
			if (s > QUIET_SPEED) begin
				vib = (s * s * 64'd14) / (64'd50625 * 64'd65536);
				if (s > RES_LOW && s < RES_HIGH) begin
					off_mid = (s >= RES_CENTER) ? s - RES_CENTER : RES_CENTER - s;
					vib = vib + ((RES_WIDTH - off_mid) * 64'd2) / 64'd25;
				end
				if (s > OVERSPEED)
					vib = vib + ((s - OVERSPEED) * 64'd8) / 64'd25;
				if (vib > VIB_TOP)
					vib = VIB_TOP;
			end
			res.speed = s[19:0];
			res.inflow = inflow[14:0];
			res.vib = vib[15:0];
			pending_results.push_back(res);
		endfunction

		task check_result(logic [19:0] speed, logic [14:0] inflow, logic [15:0] vib);
			stp_pkg::result_t exp_res;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing pending: speed %0d inflow %0d vib %0d",
					speed, inflow, vib));
			end else begin
				exp_res = pending_results.pop_front();
				if (speed !== exp_res.speed)
					report($sformatf("turbine_speed %0d, expected %0d", speed, exp_res.speed));
				if (inflow !== exp_res.inflow)
					report($sformatf("inflow_percent %0d, expected %0d", inflow,
						exp_res.inflow));
				if (vib !== exp_res.vib)
					report($sformatf("vibration %0d, expected %0d", vib, exp_res.vib));
			end
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] drum_pressure = '0;
	logic valve_open = 1'b0;
	logic [11:0] time_step = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [19:0] turbine_speed;
	logic [14:0] inflow_percent;
	logic [15:0] vibration;

	turbine_scoreboard sb;
	int cycle_count = 0;
	int stall_left = 0;
	rx_mode_t stall_mode = RX_FLOW;

	steam_turbine_plant_step_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.drum_pressure(drum_pressure),
		.valve_open(valve_open),
		.time_step(time_step),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.turbine_speed(turbine_speed),
		.inflow_percent(inflow_percent),
		.vibration(vibration)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycle_count,
				sb.pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Take results and stall on a pattern of flowing, held and choppy stretches
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(turbine_speed, inflow_percent, vibration);
			if (stall_left == 0) begin
				case ($urandom_range(0, 3))
					0: stall_mode = RX_HOLD;
					1: stall_mode = RX_CHOPPY;
					default: stall_mode = RX_FLOW;
				endcase
				stall_left = (stall_mode == RX_HOLD) ? int'($urandom_range(1, 12)) :
					int'($urandom_range(1, 40));
			end
			stall_left = stall_left - 1;
			case (stall_mode)
				RX_FLOW: out_ready <= 1'b1;
				RX_HOLD: out_ready <= 1'b0;
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Offer one tick and hold it until accepted; valid stays high on return
	task automatic send_tick(input logic [15:0] b, input logic v, input logic [11:0] dt);
		in_valid <= 1'b1;
		drum_pressure <= b;
		valve_open <= v;
		time_step <= dt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_tick(b, v, dt);
	endtask

	// Wait until every queued result has come back
	task automatic wait_idle();
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write all three registers, optionally poking the unused index too
	task automatic program_regs(input logic [15:0] atm_v, input logic [15:0] spin_v,
			input logic [15:0] fric_v, input bit poke_unused);
		logic [1:0] idx;
		logic [15:0] data;
		int k;
		for (k = 0; k < (poke_unused ? 4 : 3); k++) begin
			case (k)
				0: begin
					idx = stp_pkg::CFG_ATM;
					data = atm_v;
				end
				1: begin
					idx = stp_pkg::CFG_SPIN;
					data = spin_v;
				end
				2: begin
					idx = stp_pkg::CFG_FRIC;
					data = fric_v;
				end
				default: begin
					idx = REG_UNUSED;
					data = 16'($urandom);
				end
			endcase
			cfg_wen <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
			sb.write_reg(idx, data);
		end
		cfg_wen <= 1'b0;
	endtask

	// Extremes, thresholds and the zero step, back to back at reset settings
	task automatic run_directed();
		int k;
		for (k = 0; k < 6; k++)
			send_tick(16'hFFFF, 1'b1, 12'hFFF);
		send_tick(16'hFFFF, 1'b1, 12'h000);
		send_tick(16'h0000, 1'b1, 12'hFFF);
		send_tick(16'hFFFF, 1'b0, 12'hFFF);
		send_tick(ATM_DEFAULT, 1'b1, 12'hFFF);
		send_tick(ATM_DEFAULT + 16'd1, 1'b1, 12'hFFF);
		for (k = 0; k < 5; k++)
			send_tick(ATM_DEFAULT + 16'd800, 1'b1, 12'hFFF);
		send_tick(ATM_DEFAULT + 16'd1599, 1'b1, 12'h800);
		send_tick(ATM_DEFAULT + 16'd1600, 1'b1, 12'h001);
		send_tick(16'h5555, 1'b0, 12'h555);
		send_tick(16'hAAAA, 1'b1, 12'hAAA);
		in_valid <= 1'b0;
	endtask

	// Bursts of spin-up toward a held target, coast-down or noise, with random gaps
	task automatic run_random(input int count);
		int sent, burst, gap, k, offset, press;
		tick_kind_t kind;
		logic [15:0] b;
		logic v;
		logic [11:0] dt;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: kind = TICK_SPIN;
				5, 6: kind = TICK_COAST;
				default: kind = TICK_NOISE;
			endcase
			offset = $urandom_range(1, 1800);
			for (k = 0; k < burst && sent < count; k++) begin
				dt = 12'($urandom_range(0, 4095));
				case (kind)
					TICK_SPIN: begin
						press = int'(sb.atm) + offset + int'($urandom_range(0, 3));
						b = (press > 65535) ? 16'hFFFF : press[15:0];
						v = 1'b1;
						if ($urandom_range(0, 1))
							dt = 12'($urandom_range(1024, 4095));
					end
					TICK_COAST: begin
						b = 16'($urandom);
						v = 1'b0;
					end
					default: begin
						b = 16'($urandom);
						v = 1'($urandom_range(0, 1));
					end
				endcase
				send_tick(b, v, dt);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 16));
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_idle();
		run_random(ITEMS_PER_PHASE);

		// Step through register settings, extremes first
		for (int phase = 1; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				1: program_regs(16'h0000, 16'hFFFF, 16'h0FFF, 1'b1);
				2: program_regs(16'hFFFF, 16'hF000, 16'h0000, 1'b0);
				3: program_regs(16'($urandom_range(0, 4000)), 16'($urandom), 16'($urandom),
					1'b1);
				4: program_regs(16'd1000, 16'd4095, 16'd1, 1'b0);
				5: program_regs(ATM_DEFAULT, 16'd328, 16'd82, 1'b1);
				default: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
			endcase
			run_random(ITEMS_PER_PHASE);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
